[sv/cvs_pkg.sv]
package cvs_pkg;

   localparam int CAPACITY      = 256;
   localparam int ELEMENT_WIDTH = 32;
   localparam int ADDR_WIDTH    = $clog2(CAPACITY);
   localparam int COUNT_WIDTH   = $clog2(CAPACITY + 1);

   localparam logic [1:0] CMD_PUSH   = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_BAD_INDEX = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] value;
      logic [7:0]  index;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] element;
      logic [1:0]  status;
      logic [8:0]  count;
   } rsp_payload_type;

   // What the back end has to do once a request has been checked.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_PUSH,
      OP_READ,
      OP_REMOVE
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [1:0]               status;
      logic [ADDR_WIDTH-1:0]    addr;
      logic [ELEMENT_WIDTH-1:0] value;
      logic [COUNT_WIDTH-1:0]   count_after;
   } work_entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_SHIFT,
      BK_DONE
   } back_state_type;

   function automatic logic [ELEMENT_WIDTH-1:0] to_elem(input logic [31:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[ELEMENT_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] from_elem(input logic [ELEMENT_WIDTH-1:0] e);
      logic [63:0] w;
      w = 64'(e);
      return w[31:0];
   endfunction

endpackage

[sv/compacting_vector_store.sv]
// Bounded vector of cvs_pkg::CAPACITY elements kept packed from position zero,
// with push, read-at-index and remove-at-index requests, one response each that
// carries the element, a status and the element count after the request. A
// request is checked and counted on entry and placed in a two-entry queue, so
// the port keeps taking requests while the store is busy or a response waits,
// until that queue is full. The store is a single memory with one write and
// one registered read port, and that port pair sets the pace. In the back end
// a push, a refused request or an unused command goes from idle straight to
// done, a read passes a fetch state first, and a remove that is not of the last
// element also passes a shift state, where every later element is moved down one place per cycle.
// Stored entries are not cleared after reset; only positions below the count
// are ever read.
module compacting_vector_store (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cvs_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cvs_pkg::rsp_payload_type rsp_data
);

   logic                    q_full;
   logic                    q_push;
   cvs_pkg::work_entry_type q_entry;
   logic                    q_pop;
   logic                    q_not_empty;
   cvs_pkg::work_entry_type q_head;

   cvs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   cvs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   cvs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

[sv/cvs_front.sv]
module cvs_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cvs_pkg::req_payload_type req_data,
   input  logic                     q_full,
   output logic                     q_push,
   output cvs_pkg::work_entry_type  q_entry
);

   logic [cvs_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [cvs_pkg::COUNT_WIDTH-1:0] count_in;
   logic                            accept;
   logic                            is_full;
   logic                            bad_index;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign is_full   = (count_ff == cvs_pkg::COUNT_WIDTH'(cvs_pkg::CAPACITY));
   assign bad_index = (32'(req_data.index) >= 32'(count_ff));

   // The count is kept here, so every request is settled before the store is touched.
   always_comb begin
      q_entry.op          = cvs_pkg::OP_NONE;
      q_entry.status      = cvs_pkg::ST_OK;
      q_entry.addr        = cvs_pkg::ADDR_WIDTH'(req_data.index);
      q_entry.value       = cvs_pkg::to_elem(req_data.value);
      q_entry.count_after = count_ff;
      unique case (req_data.cmd) inside
         cvs_pkg::CMD_PUSH: begin
            if (is_full) begin
               q_entry.status = cvs_pkg::ST_FULL;
            end else begin
               q_entry.op          = cvs_pkg::OP_PUSH;
               q_entry.addr        = cvs_pkg::ADDR_WIDTH'(count_ff);
               q_entry.count_after = count_ff + 1'b1;
            end
         end
         cvs_pkg::CMD_READ, cvs_pkg::CMD_REMOVE: begin
            if (bad_index) begin
               q_entry.status = cvs_pkg::ST_BAD_INDEX;
            end else if (req_data.cmd == cvs_pkg::CMD_READ) begin
               q_entry.op = cvs_pkg::OP_READ;
            end else begin
               q_entry.op          = cvs_pkg::OP_REMOVE;
               q_entry.count_after = count_ff - 1'b1;
            end
         end
         default: begin
            q_entry.op = cvs_pkg::OP_NONE;
         end
      endcase
   end

   assign q_push   = accept;
   assign count_in = accept ? q_entry.count_after : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

[sv/cvs_queue.sv]
module cvs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  cvs_pkg::work_entry_type push_entry,
   output logic                    full,
   input  logic                    pop,
   output logic                    not_empty,
   output cvs_pkg::work_entry_type head
);

   localparam int QDEPTH = 2;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int FILL_W = $clog2(QDEPTH + 1);

   cvs_pkg::work_entry_type slot_ff [QDEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff;
   logic [PTR_W-1:0]        wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff;
   logic [PTR_W-1:0]        rd_ptr_in;
   logic [FILL_W-1:0]       fill_ff;
   logic [FILL_W-1:0]       fill_in;
   logic                    do_push;
   logic                    do_pop;

   assign full      = (fill_ff == FILL_W'(QDEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/cvs_back.sv]
module cvs_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_not_empty,
   input  cvs_pkg::work_entry_type  q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cvs_pkg::rsp_payload_type rsp_data
);

   logic [cvs_pkg::ELEMENT_WIDTH-1:0] mem [cvs_pkg::CAPACITY];
   logic [cvs_pkg::ELEMENT_WIDTH-1:0] rd_data_ff;

   cvs_pkg::back_state_type           state_ff;
   cvs_pkg::back_state_type           state_in;
   cvs_pkg::work_entry_type           cur_ff;
   cvs_pkg::work_entry_type           cur_in;
   logic [cvs_pkg::ADDR_WIDTH-1:0]    ptr_ff;
   logic [cvs_pkg::ADDR_WIDTH-1:0]    ptr_in;
   logic [cvs_pkg::ELEMENT_WIDTH-1:0] elem_ff;
   logic [cvs_pkg::ELEMENT_WIDTH-1:0] elem_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   cvs_pkg::rsp_payload_type          rsp_data_ff;
   cvs_pkg::rsp_payload_type          rsp_data_in;

   logic                              mem_we;
   logic [cvs_pkg::ADDR_WIDTH-1:0]    mem_waddr;
   logic [cvs_pkg::ELEMENT_WIDTH-1:0] mem_wdata;
   logic                              mem_re;
   logic [cvs_pkg::ADDR_WIDTH-1:0]    mem_raddr;
   logic                              rsp_load;
   logic                              rsp_free;
   logic                              shift_needed;
   logic                              shift_more;
   logic [cvs_pkg::COUNT_WIDTH-1:0]   ptr_next;

   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   // A remove only moves anything when the removed element was not the last one.
   assign shift_needed = (cvs_pkg::COUNT_WIDTH'(cur_ff.addr) < cur_ff.count_after);
   assign ptr_next     = cvs_pkg::COUNT_WIDTH'(ptr_ff) + 1'b1;
   assign shift_more   = (ptr_next < cur_ff.count_after);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cvs_pkg::BK_IDLE: begin
            if (q_not_empty) begin
               if (q_head.op == cvs_pkg::OP_READ || q_head.op == cvs_pkg::OP_REMOVE) begin
                  state_in = cvs_pkg::BK_FETCH;
               end else begin
                  state_in = cvs_pkg::BK_DONE;
               end
            end
         end
         cvs_pkg::BK_FETCH: begin
            if (cur_ff.op == cvs_pkg::OP_REMOVE && shift_needed) begin
               state_in = cvs_pkg::BK_SHIFT;
            end else begin
               state_in = cvs_pkg::BK_DONE;
            end
         end
         cvs_pkg::BK_SHIFT: begin
            if (!shift_more) begin
               state_in = cvs_pkg::BK_DONE;
            end
         end
         cvs_pkg::BK_DONE: begin
            if (rsp_free) begin
               state_in = cvs_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = cvs_pkg::BK_IDLE;
         end
      endcase
   end

   // The shift is pipelined: the element read last cycle is written one place
   // lower while the element two places up is read.
   always_comb begin
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = ptr_ff;
      mem_wdata = rd_data_ff;
      mem_re    = 1'b0;
      mem_raddr = cur_ff.addr;
      rsp_load  = 1'b0;
      cur_in    = cur_ff;
      ptr_in    = ptr_ff;
      elem_in   = elem_ff;
      unique case (state_ff)
         cvs_pkg::BK_IDLE: begin
            if (q_not_empty) begin
               q_pop   = 1'b1;
               cur_in  = q_head;
               elem_in = '0;
               if (q_head.op == cvs_pkg::OP_PUSH) begin
                  mem_we    = 1'b1;
                  mem_waddr = q_head.addr;
                  mem_wdata = q_head.value;
               end else if (q_head.op == cvs_pkg::OP_READ
                            || q_head.op == cvs_pkg::OP_REMOVE) begin
                  mem_re    = 1'b1;
                  mem_raddr = q_head.addr;
               end
            end
         end
         cvs_pkg::BK_FETCH: begin
            elem_in = rd_data_ff;
            ptr_in  = cur_ff.addr;
            if (cur_ff.op == cvs_pkg::OP_REMOVE && shift_needed) begin
               mem_re    = 1'b1;
               mem_raddr = cur_ff.addr + 1'b1;
            end
         end
         cvs_pkg::BK_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = rd_data_ff;
            ptr_in    = cvs_pkg::ADDR_WIDTH'(ptr_next);
            if (shift_more) begin
               mem_re    = 1'b1;
               mem_raddr = cvs_pkg::ADDR_WIDTH'(ptr_next + 1'b1);
            end
         end
         cvs_pkg::BK_DONE: begin
            rsp_load = rsp_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_data_in.element = cvs_pkg::from_elem(elem_ff);
      rsp_data_in.status  = cur_ff.status;
      rsp_data_in.count   = 9'(cur_ff.count_after);
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cvs_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      ptr_ff  <= ptr_in;
      elem_ff <= elem_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
